FILE: src/u8sb_pkg.sv
package u8sb_pkg;

    localparam logic [7:0] QMARK = 8'h3F;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } byte_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       text_done;
    } code_item_t;

    // U+00-7F, U+A0-FF pass; Polish letters fold to their ASCII base letter
    function automatic logic [7:0] map_code(input logic [20:0] cp);
        logic [7:0] res;
        res = QMARK;
        if (cp < 21'h80 || (cp >= 21'hA0 && cp <= 21'hFF))
        begin
            res = cp[7:0];
        end
        else
        begin
            unique case (cp)
                21'h0104: res = "A";
                21'h0105: res = "a";
                21'h0106: res = "C";
                21'h0107: res = "c";
                21'h0118: res = "E";
                21'h0119: res = "e";
                21'h0141: res = "L";
                21'h0142: res = "l";
                21'h0143: res = "N";
                21'h0144: res = "n";
                21'h015A: res = "S";
                21'h015B: res = "s";
                21'h0179: res = "Z";
                21'h017A: res = "z";
                21'h017B: res = "Z";
                21'h017C: res = "z";
                default:  res = QMARK;
            endcase
        end
        return res;
    endfunction

endpackage

FILE: src/utf8_to_single_byte_transcoder_core.sv
// Path: a byte transaction goes through the input register, then the result register.
// Throughput: one byte per cycle while code_stall is low and each byte gives at most one
// result; a byte that gives n results (malformed input, up to 4) stalls the input side
// until the single result register has replayed its run of n results.
// Reset: rst_n asynchronous active low; clears the open sequence and both valid flags.
module utf8_to_single_byte_transcoder_core
    import u8sb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  byte_item_t byte_data,
    output logic       code_valid,
    input  logic       code_stall,
    output code_item_t code_data
);

    // input register
    logic       s1_valid_reg;
    byte_item_t s1_data_reg;

    // decoder state
    logic [20:0] acc_reg, acc_next;
    logic [1:0]  exp_reg, exp_next;
    logic [1:0]  taken_reg, taken_next;

    // result batch: all '?' except an optional mid value
    logic       bat_valid_reg;
    logic [2:0] bat_cnt_reg;
    logic [1:0] bat_idx_reg;
    logic       bat_has_mid_reg;
    logic [1:0] bat_mid_pos_reg;
    logic [7:0] bat_mid_val_reg;
    logic       bat_eot_reg;

    logic        cont;
    logic [20:0] acc_cat;
    logic [1:0]  taken_inc;
    logic [2:0]  c1, c3, n_res;
    logic        has_mid;
    logic [7:0]  mid_val;
    logic        bat_last, bat_done, s1_go, s1_fire;

    assign bat_last = ({1'b0, bat_idx_reg} == (bat_cnt_reg - 3'd1));
    assign bat_done = bat_valid_reg && !code_stall && bat_last;
    assign s1_go    = !bat_valid_reg || bat_done;
    assign s1_fire  = s1_valid_reg && s1_go;

    assign byte_stall = s1_valid_reg && !s1_go;

    assign code_valid          = bat_valid_reg;
    assign code_data.out_byte  = (bat_has_mid_reg && bat_idx_reg == bat_mid_pos_reg)
                                 ? bat_mid_val_reg : QMARK;
    assign code_data.run_last  = bat_last;
    assign code_data.text_done = bat_last && bat_eot_reg;

    always_comb
    begin
        cont       = (s1_data_reg.in_byte[7:6] == 2'b10);
        acc_cat    = {acc_reg[14:0], s1_data_reg.in_byte[5:0]};
        taken_inc  = taken_reg + 2'd1;
        acc_next   = acc_reg;
        exp_next   = exp_reg;
        taken_next = taken_reg;
        c1         = 3'd0;
        c3         = 3'd0;
        has_mid    = 1'b0;
        mid_val    = QMARK;
        if (exp_reg != 2'd0 && cont)
        begin
            if (taken_inc == exp_reg)
            begin
                has_mid    = 1'b1;
                mid_val    = map_code(acc_cat);
                acc_next   = '0;
                exp_next   = 2'd0;
                taken_next = 2'd0;
            end
            else
            begin
                acc_next   = acc_cat;
                taken_next = taken_inc;
            end
        end
        else
        begin
            // no open form or bad continuation: flush any open form, then treat the byte as a lead
            if (exp_reg != 2'd0)
            begin
                c1 = {1'b0, taken_reg} + 3'd1;
            end
            acc_next   = '0;
            exp_next   = 2'd0;
            taken_next = 2'd0;
            priority if (!s1_data_reg.in_byte[7])
            begin
                has_mid = 1'b1;
                mid_val = s1_data_reg.in_byte;
            end
            else if (s1_data_reg.in_byte[7:5] == 3'b110)
            begin
                exp_next = 2'd1;
                acc_next = {16'd0, s1_data_reg.in_byte[4:0]};
            end
            else if (s1_data_reg.in_byte[7:4] == 4'b1110)
            begin
                exp_next = 2'd2;
                acc_next = {17'd0, s1_data_reg.in_byte[3:0]};
            end
            else if (s1_data_reg.in_byte[7:3] == 5'b11110)
            begin
                exp_next = 2'd3;
                acc_next = {18'd0, s1_data_reg.in_byte[2:0]};
            end
            else
            begin
                has_mid = 1'b1;
                mid_val = QMARK;
            end
        end
        // truncated text
        if (s1_data_reg.end_of_text && exp_next != 2'd0)
        begin
            c3         = {1'b0, taken_next} + 3'd1;
            acc_next   = '0;
            exp_next   = 2'd0;
            taken_next = 2'd0;
        end
        n_res = c1 + {2'b00, has_mid} + c3;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            bat_valid_reg <= 1'b0;
            acc_reg       <= '0;
            exp_reg       <= 2'd0;
            taken_reg     <= 2'd0;
            bat_idx_reg   <= 2'd0;
        end
        else
        begin
            if (byte_valid && !byte_stall)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_fire)
            begin
                acc_reg   <= acc_next;
                exp_reg   <= exp_next;
                taken_reg <= taken_next;
            end

            if (s1_fire && n_res != 3'd0)
            begin
                bat_valid_reg <= 1'b1;
                bat_idx_reg   <= 2'd0;
            end
            else if (bat_done)
            begin
                bat_valid_reg <= 1'b0;
            end
            else if (bat_valid_reg && !code_stall)
            begin
                bat_idx_reg <= bat_idx_reg + 2'd1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
        begin
            s1_data_reg <= byte_data;
        end
        if (s1_fire && n_res != 3'd0)
        begin
            bat_cnt_reg     <= n_res;
            bat_has_mid_reg <= has_mid;
            bat_mid_pos_reg <= c1[1:0];
            bat_mid_val_reg <= mid_val;
            bat_eot_reg     <= s1_data_reg.end_of_text;
        end
    end

endmodule

FILE: src/u8sb_checker.sv
module u8sb_checker
    import u8sb_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       byte_valid,
    input logic       byte_stall,
    input byte_item_t byte_data,
    input logic       code_valid,
    input logic       code_stall,
    input code_item_t code_data
);

    // a stalled byte transaction holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && byte_stall |=> byte_valid && $stable(byte_data))
        else $error("stalled byte changed");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        code_valid && code_stall |=> code_valid && $stable(code_data))
        else $error("stalled result changed");

    // only the last result of a run can carry a real code
    a_mid_last: assert property (@(posedge clk) disable iff (!rst_n)
        code_valid && !code_data.run_last |-> code_data.out_byte == QMARK)
        else $error("non-last result is not a replacement mark");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        code_valid && code_data.text_done |-> code_data.run_last)
        else $error("text_done outside the last result of a run");

    // a run continues without a gap
    a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
        code_valid && !code_stall && !code_data.run_last |=> code_valid)
        else $error("result run broken");

endmodule

bind utf8_to_single_byte_transcoder_core u8sb_checker chk (.*);
